// File: design/multitouch_calibrate_and_track_core_defines.svh
// assertion macros for the multitouch calibrate and track block
// used by the controller
`ifndef MULTITOUCH_CALIBRATE_AND_TRACK_CORE_DEFINES_SVH
`define MULTITOUCH_CALIBRATE_AND_TRACK_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define MT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication outside reset
`define MT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: design/mtct_pkg.sv
// package for the multitouch calibrate and track block
// types, constants and controller states; no dependencies
package mtct_pkg;
  localparam int MAX_SLOTS = 5;
  localparam int COORD_BITS = 12;
  localparam int SLOT_BITS = $clog2(MAX_SLOTS);
  localparam int CNT_BITS = $clog2(MAX_SLOTS + 1);
  localparam int SU_BITS = 3;
  localparam int DIST_BITS = 2 * COORD_BITS + 1;
  localparam int MIN_SPAN = 20;
  localparam int DIST_DIV = 3;
  localparam int DIST_FALLBACK = 150;
  localparam int PROD_BITS = 2 * COORD_BITS;
  localparam int DIV_STEP_BITS = $clog2(PROD_BITS + 1);
  // x / 3 as (x * 2731) >> 13, exact for every 12-bit x
  localparam int DIV3_RECIP = 2731;
  localparam int DIV3_SHIFT = 13;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SLOT_BITS-1:0] slot_idx_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef enum logic [2:0] {
    REG_CALIB_ON = 3'd0, REG_CX_MIN = 3'd1, REG_CX_MAX = 3'd2,
    REG_CY_MIN = 3'd3, REG_CY_MAX = 3'd4, REG_SX_MAX = 3'd5,
    REG_SY_MAX = 3'd6, REG_SLOTS = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_X, ST_DIV_Y, ST_STORE, ST_TRK, ST_TRK_END,
    ST_NEW, ST_EMIT
  } state_t;

  typedef struct packed {
    logic     buf_clear;
    logic     div_start_x;
    logic     div_start_y;
    logic     store_pt;
    logic     trk_init;
    logic     trk_step;
    logic     trk_done;
    logic     new_step;
    logic     round_done;
    slot_idx_t slot;
    slot_idx_t pt;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic calib_act;
    logic buf_full;
    cnt_t pt_count;
    cnt_t ns;
    logic slot_busy;
  } stat_t;
endpackage

// File: design/mtct_if.sv
// valid/ready stream interfaces for the multitouch block
// depends on mtct_pkg for the coordinate type
interface mtct_in_if (input logic clk);
  import mtct_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   point_present;
  logic   round_end;
  modport source (output valid, point_x, point_y, point_present, round_end, input ready);
  modport sink (input valid, point_x, point_y, point_present, round_end, output ready);
endinterface

interface mtct_out_if (input logic clk);
  import mtct_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] slot_index;
  logic       slot_pressed;
  coord_t     slot_x;
  coord_t     slot_y;
  logic       last_slot;
  modport source (output valid, slot_index, slot_pressed, slot_x, slot_y, last_slot,
                  input ready);
  modport sink (input valid, slot_index, slot_pressed, slot_x, slot_y, last_slot,
                output ready);
endinterface

// File: design/mtct_div.sv
// restoring divider for the calibration rescale, one quotient bit a cycle
// depends on mtct_pkg
module mtct_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [mtct_pkg::PROD_BITS-1:0] dividend,
  input  logic [mtct_pkg::COORD_BITS-1:0] divisor,
  output logic busy,
  output logic [mtct_pkg::PROD_BITS-1:0] quotient
);
  import mtct_pkg::*;
  logic [DIV_STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic [PROD_BITS-1:0] q_r, q_nxt;
  logic [COORD_BITS:0] rem_r, rem_nxt;
  logic [COORD_BITS-1:0] dvs_r;
  logic [COORD_BITS:0] trial;

  always_comb begin
    trial = {rem_r[COORD_BITS-1:0], q_r[PROD_BITS-1]};
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = DIV_STEP_BITS'(PROD_BITS);
      q_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt = {q_r[PROD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[PROD_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign busy = (cnt_r != '0);
  assign quotient = q_r;
endmodule

// File: design/mtct_datapath.sv
// datapath: config registers, point buffer, slot state, rescale and distance
// depends on mtct_pkg and mtct_div
module mtct_datapath (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [11:0] cfg_wdata,
  input  mtct_pkg::coord_t in_x,
  input  mtct_pkg::coord_t in_y,
  input  mtct_pkg::cmd_t cmd,
  output mtct_pkg::stat_t stat,
  output logic out_pressed,
  output mtct_pkg::coord_t out_x,
  output mtct_pkg::coord_t out_y
);
  import mtct_pkg::*;
  logic calib_on_r;
  coord_t cx_min_r, cx_max_r, cy_min_r, cy_max_r, sx_max_r, sy_max_r;
  logic [SU_BITS-1:0] slots_r;

  coord_t px_r, py_r, rx_r;
  coord_t pts_x_r [MAX_SLOTS];
  coord_t pts_y_r [MAX_SLOTS];
  cnt_t cnt_r;
  logic [MAX_SLOTS-1:0] busy_r, claimed_r, released_r;
  coord_t pos_x_r [MAX_SLOTS];
  coord_t pos_y_r [MAX_SLOTS];
  logic found_r;
  logic [DIST_BITS-1:0] best_r, lim_sq_r;
  slot_idx_t bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_on_r <= 1'b0; cx_min_r <= '0; cx_max_r <= '1; cy_min_r <= '0;
      cy_max_r <= '1; sx_max_r <= '0; sy_max_r <= '0; slots_r <= SU_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CALIB_ON: calib_on_r <= cfg_wdata[0];
        REG_CX_MIN: cx_min_r <= cfg_wdata;
        REG_CX_MAX: cx_max_r <= cfg_wdata;
        REG_CY_MIN: cy_min_r <= cfg_wdata;
        REG_CY_MAX: cy_max_r <= cfg_wdata;
        REG_SX_MAX: sx_max_r <= cfg_wdata;
        REG_SY_MAX: sy_max_r <= cfg_wdata;
        REG_SLOTS: slots_r <= cfg_wdata[SU_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic calib_act;
  always_comb begin
    calib_act = calib_on_r && sx_max_r != '0 && sy_max_r != '0 &&
      cx_max_r > cx_min_r && cy_max_r > cy_min_r &&
      (cx_max_r - cx_min_r) >= COORD_BITS'(MIN_SPAN) &&
      (cy_max_r - cy_min_r) >= COORD_BITS'(MIN_SPAN);
  end

  // rescale: one shared divider, x then y
  // x comes straight from the input at the transfer, y from its latch
  logic div_busy, div_start;
  logic [PROD_BITS-1:0] dividend, quot;
  coord_t divisor, sel_v, sel_lo, sel_hi, sel_t, scaled;
  logic sel_y;
  assign sel_y = cmd.div_start_y;
  assign sel_v = sel_y ? py_r : in_x;
  assign sel_lo = sel_y ? cy_min_r : cx_min_r;
  assign sel_hi = sel_y ? cy_max_r : cx_max_r;
  assign sel_t = sel_y ? sy_max_r : sx_max_r;
  assign dividend = (sel_v > sel_lo) ? (PROD_BITS'(sel_v - sel_lo) * PROD_BITS'(sel_t)) : '0;
  assign divisor = sel_hi - sel_lo;
  assign div_start = cmd.div_start_x || cmd.div_start_y;

  mtct_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dividend),
    .divisor(divisor), .busy(div_busy), .quotient(quot)
  );

  // clamp the finished quotient against the target of the axis in flight
  coord_t tgt_r;
  always_comb begin
    scaled = (quot > PROD_BITS'(tgt_r)) ? tgt_r : quot[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_x || cmd.div_start_y) tgt_r <= sel_t;
    if (cmd.div_start_x) begin
      px_r <= in_x; py_r <= in_y; rx_r <= in_x;
    end
    if (cmd.div_start_y) rx_r <= calib_act ? scaled : px_r;
  end

  // squared distance of slot cmd.slot to point cmd.pt
  coord_t ax, ay, bx, by, dx, dy;
  logic [DIST_BITS-1:0] d;
  assign ax = pts_x_r[cmd.pt];
  assign ay = pts_y_r[cmd.pt];
  assign bx = pos_x_r[cmd.slot];
  assign by = pos_y_r[cmd.slot];
  assign dx = (ax >= bx) ? ax - bx : bx - ax;
  assign dy = (ay >= by) ? ay - by : by - ay;
  assign d = DIST_BITS'(dx) * DIST_BITS'(dx) + DIST_BITS'(dy) * DIST_BITS'(dy);

  // tracking distance: width / 3 by reciprocal multiply, or the fallback for zero width
  logic [PROD_BITS-1:0] lim_prod;
  logic [COORD_BITS-1:0] lim;
  assign lim_prod = PROD_BITS'(sx_max_r) * PROD_BITS'(DIV3_RECIP);
  assign lim = (sx_max_r != '0) ? COORD_BITS'(lim_prod >> DIV3_SHIFT)
                                : COORD_BITS'(DIST_FALLBACK);

  // first free point for the new-slot pass
  logic free_found;
  slot_idx_t free_pt;
  always_comb begin
    free_found = 1'b0;
    free_pt = '0;
    for (int r = MAX_SLOTS - 1; r >= 0; r--) begin
      if (cnt_t'(r) < cnt_r && !claimed_r[r]) begin
        free_found = 1'b1;
        free_pt = slot_idx_t'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_sq_r <= DIST_BITS'(lim) * DIST_BITS'(lim);
    if (cmd.store_pt) begin
      pts_x_r[cnt_r[SLOT_BITS-1:0]] <= calib_act ? rx_r : px_r;
      pts_y_r[cnt_r[SLOT_BITS-1:0]] <= calib_act ? scaled : py_r;
    end
    if (cmd.trk_init) found_r <= 1'b0;
    if (cmd.trk_step && !claimed_r[cmd.pt] && (!found_r || d < best_r)) begin
      found_r <= 1'b1; best_r <= d; bi_r <= cmd.pt;
    end
    if (cmd.trk_done && busy_r[cmd.slot] && found_r && best_r <= lim_sq_r) begin
      pos_x_r[cmd.slot] <= pts_x_r[bi_r];
      pos_y_r[cmd.slot] <= pts_y_r[bi_r];
    end
    if (cmd.new_step && !busy_r[cmd.slot] && !released_r[cmd.slot] && free_found) begin
      pos_x_r[cmd.slot] <= pts_x_r[free_pt];
      pos_y_r[cmd.slot] <= pts_y_r[free_pt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; busy_r <= '0; claimed_r <= '0; released_r <= '0;
    end else begin
      if (cmd.buf_clear || cmd.round_done) cnt_r <= '0;
      else if (cmd.store_pt) cnt_r <= cnt_r + 1'b1;
      if (cmd.round_done) begin
        claimed_r <= '0; released_r <= '0;
      end
      if (cmd.trk_done && busy_r[cmd.slot]) begin
        if (found_r && best_r <= lim_sq_r) claimed_r[bi_r] <= 1'b1;
        else begin
          busy_r[cmd.slot] <= 1'b0; released_r[cmd.slot] <= 1'b1;
        end
      end
      if (cmd.new_step && !busy_r[cmd.slot] && !released_r[cmd.slot] && free_found) begin
        busy_r[cmd.slot] <= 1'b1; claimed_r[free_pt] <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.div_busy = div_busy;
    stat.calib_act = calib_act;
    stat.buf_full = (cnt_r >= cnt_t'(MAX_SLOTS));
    stat.pt_count = cnt_r;
    if (slots_r == '0) stat.ns = cnt_t'(1);
    else if (CNT_BITS'(slots_r) > cnt_t'(MAX_SLOTS)) stat.ns = cnt_t'(MAX_SLOTS);
    else stat.ns = cnt_t'(slots_r);
    stat.slot_busy = busy_r[cmd.slot];
  end

  assign out_pressed = busy_r[cmd.slot];
  assign out_x = busy_r[cmd.slot] ? pos_x_r[cmd.slot] : '0;
  assign out_y = busy_r[cmd.slot] ? pos_y_r[cmd.slot] : '0;
endmodule

// File: design/mtct_ctrl.sv
// controller state machine: sequences rescale, tracking, new slots, results
// depends on mtct_pkg and the defines header
`include "multitouch_calibrate_and_track_core_defines.svh"
module mtct_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic in_present,
  input  logic in_end,
  input  logic out_take,
  input  mtct_pkg::stat_t stat,
  output mtct_pkg::cmd_t cmd,
  output logic in_ready,
  output logic out_valid,
  output logic out_last
);
  import mtct_pkg::*;
  state_t state_r, state_nxt;
  slot_idx_t slot_r, slot_nxt, pt_r, pt_nxt;
  logic end_r, end_nxt;
  logic [SLOT_BITS:0] sn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; slot_r <= '0; pt_r <= '0; end_r <= 1'b0;
    end else begin
      state_r <= state_nxt; slot_r <= slot_nxt; pt_r <= pt_nxt; end_r <= end_nxt;
    end
  end

  assign sn = {1'b0, slot_r} + 1'b1;

  always_comb begin
    state_nxt = state_r; slot_nxt = slot_r; pt_nxt = pt_r; end_nxt = end_r;
    cmd = '0;
    cmd.slot = slot_r;
    cmd.pt = pt_r;
    in_ready = 1'b0; out_valid = 1'b0; out_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          end_nxt = in_end;
          slot_nxt = '0; pt_nxt = '0;
          if (!in_present) begin
            cmd.buf_clear = 1'b1;
            state_nxt = in_end ? ST_TRK : ST_IDLE;
            cmd.trk_init = 1'b1;
          end else if (stat.buf_full) begin
            state_nxt = in_end ? ST_TRK : ST_IDLE;
            cmd.trk_init = 1'b1;
          end else begin
            cmd.div_start_x = 1'b1;
            state_nxt = ST_DIV_X;
          end
        end
      end
      ST_DIV_X: if (!stat.div_busy) begin
        cmd.div_start_y = 1'b1; state_nxt = ST_DIV_Y;
      end
      ST_DIV_Y: if (!stat.div_busy) state_nxt = ST_STORE;
      ST_STORE: begin
        cmd.store_pt = 1'b1;
        cmd.trk_init = 1'b1;
        state_nxt = end_r ? ST_TRK : ST_IDLE;
      end
      ST_TRK: begin
        if (!stat.slot_busy || cnt_t'(pt_r) >= stat.pt_count) state_nxt = ST_TRK_END;
        else begin
          cmd.trk_step = 1'b1;
          if (cnt_t'(pt_r) + 1'b1 >= stat.pt_count) state_nxt = ST_TRK_END;
          else pt_nxt = pt_r + 1'b1;
        end
      end
      ST_TRK_END: begin
        cmd.trk_done = 1'b1;
        cmd.trk_init = 1'b1;
        pt_nxt = '0;
        if (CNT_BITS'(sn) >= stat.ns) begin
          slot_nxt = '0; state_nxt = ST_NEW;
        end else begin
          slot_nxt = slot_r + 1'b1; state_nxt = ST_TRK;
        end
      end
      ST_NEW: begin
        cmd.new_step = 1'b1;
        if (CNT_BITS'(sn) >= stat.ns) begin
          slot_nxt = '0; state_nxt = ST_EMIT;
        end else slot_nxt = slot_r + 1'b1;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        out_last = (CNT_BITS'(sn) >= stat.ns);
        if (out_take) begin
          if (out_last) begin
            cmd.round_done = 1'b1; slot_nxt = '0; state_nxt = ST_IDLE;
          end else slot_nxt = slot_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `MT_ASSERT_IMPL(a_ready_idle, in_ready, state_r == ST_IDLE, "ready outside idle")
  `MT_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready, "input taken while emitting")
  `MT_ASSERT_NEXT(a_last_idle, out_valid && out_last && out_take, state_r == ST_IDLE,
    "no return to idle after last transfer")
  `MT_ASSERT_IMPL(a_slot_range, out_valid, CNT_BITS'(sn) <= stat.ns, "slot beyond count")
endmodule

// File: design/multitouch_calibrate_and_track_core.sv
// multitouch calibrate and track: a stored point passes from its transfer through
// two 24-step divides, x then y, on one shared divider and a store state before the
// next ready; an ignored or empty item is taken in idle and stays there unless it ends a round
// a round end adds a tracking pass and a new-slot pass over the slots in use, then one
// result per slot in use at up to one transfer a cycle while the sink is ready
// synchronous active-low reset clears slot busy, buffer count, config and FSM state
module multitouch_calibrate_and_track_core (
  input  logic clk,
  input  logic rst_n,
  mtct_in_if.sink in_ch,
  mtct_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [11:0] cfg_wdata
);
  import mtct_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic in_fire, out_take, out_valid, out_last, in_ready;
  logic pressed;
  coord_t ox, oy;

  // a transfer on each side
  assign in_fire = in_ch.valid && in_ready;
  assign out_take = out_valid && out_ch.ready;

  mtct_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_present(in_ch.point_present),
    .in_end(in_ch.round_end), .out_take(out_take), .stat(stat), .cmd(cmd),
    .in_ready(in_ready), .out_valid(out_valid), .out_last(out_last)
  );

  mtct_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_x(in_ch.point_x), .in_y(in_ch.point_y),
    .cmd(cmd), .stat(stat), .out_pressed(pressed), .out_x(ox), .out_y(oy)
  );

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.slot_index = 3'(cmd.slot);
  assign out_ch.slot_pressed = pressed;
  assign out_ch.slot_x = ox;
  assign out_ch.slot_y = oy;
  assign out_ch.last_slot = out_last;
endmodule

// File: dv/mtct_tb_if.sv
// slot report type for the multitouch testbench top
// depends on mtct_pkg; the design's own mtct_if.sv provides the block's view
`timescale 1ns / 100ps
package mtct_tb_types;
  import mtct_pkg::*;
  typedef struct {
    logic [2:0] idx;
    logic       pressed;
    coord_t     x;
    coord_t     y;
    logic       last;
  } slot_report_t;
endpackage

// File: dv/multitouch_calibrate_and_track_core_test.sv
// testbench for the multitouch calibrate and track core
// drives points through mtct_in_if, checks slot reports from mtct_out_if
// depends on mtct_pkg, mtct_if and mtct_tb_types
`timescale 1ns / 100ps
module multitouch_calibrate_and_track_core_test;
  import mtct_pkg::*;
  import mtct_tb_types::*;

  // tracker model: calibration, point buffer, slot assignment
  class slot_tracker;
    int unsigned regs [8];
    bit          busy [MAX_SLOTS];
    int unsigned pos_x [MAX_SLOTS];
    int unsigned pos_y [MAX_SLOTS];
    int unsigned pts_x [MAX_SLOTS];
    int unsigned pts_y [MAX_SLOTS];
    int unsigned pts_n;
    slot_report_t pending [$];
    int errors;

    function new();
      regs = '{0, 0, 4095, 0, 4095, 0, 0, 1};
      foreach (busy[i]) busy[i] = 0;
      pts_n = 0;
      errors = 0;
    endfunction

    function void write_reg(int unsigned idx, int unsigned val);
      regs[idx] = (idx == REG_CALIB_ON) ? (val & 1) : (idx == REG_SLOTS) ? (val & 7) : (val & 12'hfff);
    endfunction

    function int unsigned rescale(int unsigned v, int unsigned lo, int unsigned hi,
                                  int unsigned tgt);
      longint unsigned q;
      if (v <= lo || hi <= lo) return 0;
      q = (longint'(v - lo) * tgt) / (hi - lo);
      return (q > tgt) ? tgt : int'(q);
    endfunction

    function bit calib_active();
      if (regs[REG_CALIB_ON] == 0 || regs[REG_SX_MAX] == 0 || regs[REG_SY_MAX] == 0)
        return 0;
      if (regs[REG_CX_MAX] <= regs[REG_CX_MIN] || regs[REG_CY_MAX] <= regs[REG_CY_MIN])
        return 0;
      return (regs[REG_CX_MAX] - regs[REG_CX_MIN] >= MIN_SPAN) &&
             (regs[REG_CY_MAX] - regs[REG_CY_MIN] >= MIN_SPAN);
    endfunction

    function void assign_slots(int unsigned ns);
      bit claimed [MAX_SLOTS];
      bit released [MAX_SLOTS];
      longint unsigned lim, lim_sq, best, d, dx, dy;
      int unsigned bi;
      bit found;
      foreach (claimed[i]) begin
        claimed[i] = 0;
        released[i] = 0;
      end
      lim = (regs[REG_SX_MAX] > 0) ? regs[REG_SX_MAX] / DIST_DIV : DIST_FALLBACK;
      lim_sq = lim * lim;
      // busy slots follow their nearest unclaimed point, ties to lowest index
      for (int s = 0; s < ns; s++) begin
        if (!busy[s]) continue;
        found = 0;
        best = 0;
        bi = 0;
        for (int r = 0; r < pts_n; r++) begin
          if (claimed[r]) continue;
          dx = (pts_x[r] >= pos_x[s]) ? pts_x[r] - pos_x[s] : pos_x[s] - pts_x[r];
          dy = (pts_y[r] >= pos_y[s]) ? pts_y[r] - pos_y[s] : pos_y[s] - pts_y[r];
          d = dx * dx + dy * dy;
          if (!found || d < best) begin
            found = 1;
            best = d;
            bi = r;
          end
        end
        if (found && best <= lim_sq) begin
          claimed[bi] = 1;
          pos_x[s] = pts_x[bi];
          pos_y[s] = pts_y[bi];
        end else begin
          busy[s] = 0;
          released[s] = 1;
        end
      end
      // leftover points go to the first idle slot not released this round
      for (int r = 0; r < pts_n; r++) begin
        if (claimed[r]) continue;
        for (int s = 0; s < ns; s++) begin
          if (busy[s] || released[s]) continue;
          busy[s] = 1;
          pos_x[s] = pts_x[r];
          pos_y[s] = pts_y[r];
          break;
        end
      end
    endfunction

    function void note_point(int unsigned px, int unsigned py, bit present, bit rend);
      int unsigned ns;
      slot_report_t rep;
      // the block sees only the low coordinate bits
      px = px & 32'hfff;
      py = py & 32'hfff;
      if (!present) pts_n = 0;
      else if (pts_n < MAX_SLOTS) begin
        if (calib_active()) begin
          px = rescale(px, regs[REG_CX_MIN], regs[REG_CX_MAX], regs[REG_SX_MAX]);
          py = rescale(py, regs[REG_CY_MIN], regs[REG_CY_MAX], regs[REG_SY_MAX]);
        end
        pts_x[pts_n] = px;
        pts_y[pts_n] = py;
        pts_n++;
      end
      if (!rend) return;
      ns = (regs[REG_SLOTS] == 0) ? 1 : (regs[REG_SLOTS] > MAX_SLOTS) ? MAX_SLOTS
                                                                       : regs[REG_SLOTS];
      assign_slots(ns);
      pts_n = 0;
      for (int s = 0; s < ns; s++) begin
        rep.idx = 3'(s);
        rep.pressed = busy[s];
        rep.x = busy[s] ? coord_t'(pos_x[s]) : '0;
        rep.y = busy[s] ? coord_t'(pos_y[s]) : '0;
        rep.last = (s + 1 == ns);
        pending.push_back(rep);
      end
    endfunction

    function void check_report(slot_report_t act);
      slot_report_t exp;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected slot report idx %0d", $time, act.idx);
        return;
      end
      exp = pending.pop_front();
      if (exp.idx !== act.idx || exp.pressed !== act.pressed || exp.x !== act.x ||
          exp.y !== act.y || exp.last !== act.last) begin
        errors++;
        $display("%0t: mismatch exp idx %0d p %0d x %0d y %0d last %0d", $time,
                 exp.idx, exp.pressed, exp.x, exp.y, exp.last);
        $display("%0t:          act idx %0d p %0d x %0d y %0d last %0d", $time,
                 act.idx, act.pressed, act.x, act.y, act.last);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [11:0] cfg_wdata = '0;

  mtct_in_if in_ch (clk);
  mtct_out_if out_ch (clk);

  multitouch_calibrate_and_track_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  slot_tracker tracker = new();
  bit          calm;  // stretch with no idling on either side
  int          idle_cycles;

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_present = 0;
    in_ch.round_end = 0;
    out_ch.ready = 0;
  end

  // sink side: random backpressure, check every transfer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_report('{out_ch.slot_index, out_ch.slot_pressed, out_ch.slot_x,
                             out_ch.slot_y, out_ch.last_slot});
    out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 34);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= 12'(val);
    tracker.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // one point transfer; random gap before it unless calm
  task automatic send_point(int unsigned px, int unsigned py, bit present, bit rend);
    if (!calm && $urandom_range(99) < 34) begin
      in_ch.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    in_ch.valid <= 1;
    in_ch.point_x <= coord_t'(px);
    in_ch.point_y <= coord_t'(py);
    in_ch.point_present <= present;
    in_ch.round_end <= rend;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_point(px, py, present, rend);
  endtask

  // wait until all reports are in, then let in-flight work drain
  task automatic drain();
    in_ch.valid <= 0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // a round of n points spread from a random base, some fully random, then a round end
  task automatic send_round(int unsigned n);
    int unsigned bx, by;
    bx = $urandom_range(4095);
    by = $urandom_range(4095);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_point($urandom, $urandom, 1, 0);
      else send_point((bx + $urandom_range(60) + i * 300) & 12'hfff,
                      (by + $urandom_range(60)) & 12'hfff, 1, 0);
    end
    if ($urandom_range(9) == 0) send_point($urandom, $urandom, 0, $urandom_range(1));
    send_point((bx + $urandom_range(40)) & 12'hfff, (by + $urandom_range(40)) & 12'hfff,
               $urandom_range(9) != 0, 1);
  endtask

  task automatic random_config();
    int unsigned lo;
    write_reg(REG_CALIB_ON, $urandom_range(1));
    lo = $urandom_range(500);
    write_reg(REG_CX_MIN, lo);
    write_reg(REG_CX_MAX, ($urandom_range(3) == 0) ? lo + $urandom_range(25)
                                                   : $urandom_range(4095, 3500));
    lo = $urandom_range(500);
    write_reg(REG_CY_MIN, lo);
    write_reg(REG_CY_MAX, ($urandom_range(3) == 0) ? lo + 19 : $urandom_range(4095, 3500));
    write_reg(REG_SX_MAX, ($urandom_range(4) == 0) ? 0 : $urandom_range(4095));
    write_reg(REG_SY_MAX, ($urandom_range(4) == 0) ? 0 : $urandom_range(4095));
    write_reg(REG_SLOTS, $urandom_range(7));
  endtask

  initial begin
    int sent;
    calm = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: raw pass-through, extremes, tracking, release, buffer overflow
    write_reg(REG_SLOTS, 5);
    send_point(0, 0, 1, 0);
    send_point(4095, 4095, 1, 1);
    send_point(10, 10, 1, 0);           // follows slot near origin
    send_point(4095, 4000, 1, 1);
    send_point(0, 0, 0, 1);             // empty round releases all
    for (int i = 0; i < 6; i++) send_point(i * 700, 4095 - i * 700, 1, i == 5);
    send_point(1, 1, 1, 0);
    send_point(0, 0, 0, 0);             // failed read drops buffer
    send_point(2100, 1400, 1, 1);
    drain();
    // calibrated, below min, above max, minimum valid span
    write_reg(REG_CALIB_ON, 1);
    write_reg(REG_CX_MIN, 100);
    write_reg(REG_CX_MAX, 120);
    write_reg(REG_CY_MIN, 4000);
    write_reg(REG_CY_MAX, 4095);
    write_reg(REG_SX_MAX, 4095);
    write_reg(REG_SY_MAX, 4095);
    send_point(50, 3000, 1, 0);
    send_point(4095, 4095, 1, 0);
    send_point(110, 4050, 1, 1);
    drain();
    write_reg(REG_SLOTS, 0);
    send_point(4095, 0, 1, 1);
    drain();
    write_reg(REG_CX_MAX, 119);         // span 19 disables rescale
    write_reg(REG_SLOTS, 7);
    send_point(2048, 2048, 1, 1);
    send_point(2047, 2049, 1, 1);
    drain();

    // random phases, the first one with no idling at all
    sent = 0;
    while (sent < 450) begin
      random_config();
      calm = (sent == 0) || ($urandom_range(5) == 0);
      for (int r = 0; r < 12; r++) begin
        int unsigned n;
        n = $urandom_range(6);
        send_round(n);
        sent += n + 1;
      end
      drain();
    end
    calm = 0;
    drain();
    if (tracker.errors == 0 && tracker.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
